/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define PRF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define PRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/prf_pkg.sv */
package prf_pkg;

   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int CFG_FRAMES_W = 4;
   localparam logic [CFG_FRAMES_W-1:0] CFG_FRAMES_RESET = 4'd4;

   localparam int SLOT_W   = 3;
   localparam int EVICT_W  = 16;
   localparam int FAULT_W  = 32;
   localparam int FILLED_W = 4;

   typedef enum logic {
      POLICY_LRU  = 1'b0,
      POLICY_FIFO = 1'b1
   } policy_type;

   typedef enum logic {
      CSR_POLICY = 1'b0,
      CSR_FRAMES = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic hit;
      logic evict;
   } prf_status_type;

endpackage

/* rtl/prf_if.sv */
interface prf_req_if #(parameter int PAGE_BITS = 16) ();
   logic                 valid;
   logic                 ready;
   logic [PAGE_BITS-1:0] page_number;

   modport source (output valid, output page_number, input ready);
   modport sink (input valid, input page_number, output ready);
endinterface

interface prf_rsp_if ();
   import prf_pkg::*;

   logic                valid;
   logic                ready;
   logic                hit;
   logic [SLOT_W-1:0]   frame_slot;
   logic                evicted_valid;
   logic [EVICT_W-1:0]  evicted_page;
   logic [FAULT_W-1:0]  fault_total;
   logic [FILLED_W-1:0] filled_frames;

   modport source (output valid, output hit, output frame_slot, output evicted_valid,
                   output evicted_page, output fault_total, output filled_frames,
                   input ready);
   modport sink (input valid, input hit, input frame_slot, input evicted_valid,
                 input evicted_page, input fault_total, input filled_frames,
                 output ready);
endinterface

/* rtl/page_frame_replacement_lru_fifo.sv */
// channel   | dir | beat
// ----------+-----+-----------------------------------------------------------
// req_chan  | in  | page_number
// rsp_chan  | out | hit, frame_slot, evicted_valid, evicted_page,
//           |     | fault_total, filled_frames
// apb       | in  | policy_mode at 0x0, frames_in_use at 0x4
//
// one reference per cycle unless rsp stalls; req->rsp via input, result regs
// the frame lookup, age update and fault count are all combinational from the
// input register, through the frame compare and oldest-rank search
// reset clears ranks, fill count, fault count and config; frame pages need none
// a stalled rsp holds the input register, then drops req_chan.ready

`include "assert_macros.svh"

module page_frame_replacement_lru_fifo #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   prf_req_if.sink                        req_chan,
   prf_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [prf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [prf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [prf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import prf_pkg::*;

   localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int FILL_W = $clog2(FRAMES + 1);

   policy_type               policy_ff;
   logic [CFG_FRAMES_W-1:0]  frames_cfg_ff;
   csr_index_type            csr_index;
   logic                     csr_write;

   logic                     in_valid_ff;
   logic [PAGE_BITS-1:0]     in_page_ff;
   logic                     advance;

   prf_status_type           status;
   logic [IDX_W-1:0]         slot;
   logic [PAGE_BITS-1:0]     evict_page;
   logic [FILL_W-1:0]        fill_next;

   logic [FAULT_W-1:0]       fault_ff, fault_in;

   logic                     rsp_valid_ff;
   logic                     rsp_hit_ff;
   logic [SLOT_W-1:0]        rsp_slot_ff;
   logic                     rsp_evict_ff;
   logic [EVICT_W-1:0]       rsp_evict_page_ff;
   logic [FAULT_W-1:0]       rsp_fault_ff;
   logic [FILLED_W-1:0]      rsp_filled_ff;

   // register file
   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      unique case (csr_index)
         CSR_POLICY: prdata = CSR_DATA_W'(policy_ff);
         CSR_FRAMES: prdata = CSR_DATA_W'(frames_cfg_ff);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff     <= POLICY_LRU;
         frames_cfg_ff <= CFG_FRAMES_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_POLICY: policy_ff     <= policy_type'(pwdata[0]);
            CSR_FRAMES: frames_cfg_ff <= pwdata[CFG_FRAMES_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_page_ff <= req_chan.page_number;
      end
   end

   prf_frames #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) u_frames (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .page       (in_page_ff),
      .lru        (policy_ff == POLICY_LRU),
      .cap_cfg    (frames_cfg_ff),
      .status     (status),
      .slot       (slot),
      .evict_page (evict_page),
      .fill_next  (fill_next)
   );

   // saturating fault count
   assign fault_in = (!status.hit && (fault_ff != '1)) ? fault_ff + FAULT_W'(1) : fault_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_ff <= '0;
      end else if (advance) begin
         fault_ff <= fault_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff        <= status.hit;
         rsp_slot_ff       <= SLOT_W'(slot);
         rsp_evict_ff      <= status.evict;
         rsp_evict_page_ff <= EVICT_W'(evict_page);
         rsp_fault_ff      <= fault_in;
         rsp_filled_ff     <= FILLED_W'(fill_next);
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.hit           = rsp_hit_ff;
   assign rsp_chan.frame_slot    = rsp_slot_ff;
   assign rsp_chan.evicted_valid = rsp_evict_ff;
   assign rsp_chan.evicted_page  = rsp_evict_page_ff;
   assign rsp_chan.fault_total   = rsp_fault_ff;
   assign rsp_chan.filled_frames = rsp_filled_ff;

   `PRF_ASSERT_NOW(a_evict_is_miss, rsp_valid_ff && rsp_evict_ff, !rsp_hit_ff, "eviction on a hit")
   `PRF_ASSERT_NOW(a_no_evict_zero, rsp_valid_ff && !rsp_evict_ff, rsp_evict_page_ff == '0, "evicted page not zero")
   `PRF_ASSERT_NEXT(a_hit_no_fault, advance && status.hit, fault_ff == $past(fault_ff), "fault counted on a hit")
   `PRF_ASSERT_NEXT(a_fault_monotone, advance, fault_ff >= $past(fault_ff), "fault count went down")

endmodule

/* rtl/prf_frames.sv */
module prf_frames #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16,
   localparam int IDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1,
   localparam int FILL_W   = $clog2(FRAMES + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic [PAGE_BITS-1:0]                page,
   input  logic                                lru,
   input  logic [prf_pkg::CFG_FRAMES_W-1:0]    cap_cfg,
   output prf_pkg::prf_status_type             status,
   output logic [IDX_W-1:0]                    slot,
   output logic [PAGE_BITS-1:0]                evict_page,
   output logic [FILL_W-1:0]                   fill_next
);
   import prf_pkg::*;

   localparam int CAP_W = (FILL_W > CFG_FRAMES_W) ? FILL_W : CFG_FRAMES_W;

   logic [PAGE_BITS-1:0] page_ff [FRAMES];
   logic [IDX_W-1:0]     rank_ff [FRAMES];
   logic [IDX_W-1:0]     rank_in [FRAMES];
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [FRAMES-1:0]    match, oldest;
   logic [CAP_W-1:0]     cap;
   logic                 hit_any, room;
   logic [IDX_W-1:0]     hit_idx, old_idx, slot_sel, slot_rank;

   // tag compare and oldest-frame search over the filled frames
   always_comb begin
      hit_idx = '0;
      old_idx = '0;
      for (int i = 0; i < FRAMES; i++) begin
         match[i]  = (FILL_W'(i) < fill_ff) && (page_ff[i] == page);
         oldest[i] = (FILL_W'(i) < fill_ff) &&
                     (rank_ff[i] == IDX_W'(fill_ff - FILL_W'(1)));
      end
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (oldest[i]) begin
            old_idx = IDX_W'(i);
         end
      end
      hit_any = |match;
   end

   always_comb begin
      priority if (cap_cfg == '0) begin
         cap = CAP_W'(1);
      end else if (CAP_W'(cap_cfg) > CAP_W'(FRAMES)) begin
         cap = CAP_W'(FRAMES);
      end else begin
         cap = CAP_W'(cap_cfg);
      end
      room = CAP_W'(fill_ff) < cap;
   end

   always_comb begin
      priority if (hit_any) begin
         slot_sel = hit_idx;
      end else if (room) begin
         slot_sel = IDX_W'(fill_ff);
      end else begin
         slot_sel = old_idx;
      end
      fill_in   = (!hit_any && room) ? fill_ff + FILL_W'(1) : fill_ff;
      slot_rank = rank_ff[slot_sel];
      for (int i = 0; i < FRAMES; i++) begin
         rank_in[i] = rank_ff[i];
         if (!hit_any || lru) begin
            if (IDX_W'(i) == slot_sel) begin
               rank_in[i] = '0;
            end else if ((FILL_W'(i) < fill_in) && (!hit_any || (rank_ff[i] < slot_rank))) begin
               rank_in[i] = rank_ff[i] + IDX_W'(1);
            end
         end
      end
   end

   assign status.hit   = hit_any;
   assign status.evict = !hit_any && !room;
   assign slot         = slot_sel;
   assign evict_page   = status.evict ? page_ff[old_idx] : '0;
   assign fill_next    = fill_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         for (int i = 0; i < FRAMES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (step) begin
         fill_ff <= fill_in;
         for (int i = 0; i < FRAMES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && !hit_any) begin
         page_ff[slot_sel] <= page;
      end
   end

endmodule

/* tb/sv/page_frame_replacement_lru_fifo_tb.sv */
module page_frame_replacement_lru_fifo_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import prf_pkg::*;

   localparam int NUM_FRAMES    = 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_BEATS   = 94;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] frame_slot;
      logic              evicted_valid;
      logic [15:0]       evicted_page;
      logic [31:0]       fault_total;
      logic [3:0]        filled_frames;
   } lookup_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   prf_req_if #(.PAGE_BITS(16)) req_chan ();
   prf_rsp_if rsp_chan ();

   page_frame_replacement_lru_fifo #(
      .FRAMES(NUM_FRAMES),
      .PAGE_BITS(16)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predicted frame table
   policy_type        policy_cfg;
   logic [3:0]        frames_cfg;
   logic [15:0]       resident_page [NUM_FRAMES];
   int unsigned       age_rank [NUM_FRAMES];
   int unsigned       fill_count;
   logic [31:0]       fault_count;
   lookup_result_type expected_q [$];

   int  mismatch_count;
   int  beats_sent;
   int  beats_checked;
   int  hits_seen;
   int  evictions_seen;
   int  cycle_count;
   int  stall_left;
   logic no_idle;

   function automatic int idle_length();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   function automatic int unsigned frame_capacity();
      if (frames_cfg == 4'd0) return 1;
      if (frames_cfg > NUM_FRAMES) return NUM_FRAMES;
      return frames_cfg;
   endfunction

   // frame f becomes youngest, filled frames younger than limit age by one
   function automatic void promote_frame(int unsigned f, int unsigned limit);
      for (int unsigned i = 0; i < fill_count && i < NUM_FRAMES; i++) begin
         if (i != f && age_rank[i] < limit) age_rank[i]++;
      end
      age_rank[f] = 0;
   endfunction

   function automatic lookup_result_type reference_page(logic [15:0] page);
      lookup_result_type r;
      int unsigned       n;
      int unsigned       oldest;
      int unsigned       slot;
      bit                found;
      r = '0;
      found = 1'b0;
      slot = 0;
      n = (fill_count > NUM_FRAMES) ? NUM_FRAMES : fill_count;
      for (int unsigned i = 0; i < n; i++) begin
         if (!found && resident_page[i] == page) begin
            found = 1'b1;
            slot = i;
         end
      end
      if (found) begin
         r.hit = 1'b1;
         if (policy_cfg == POLICY_LRU) promote_frame(slot, age_rank[slot]);
      end else begin
         if (fault_count != '1) fault_count++;
         if (n < frame_capacity()) begin
            slot = n;
            resident_page[slot] = page;
            fill_count = n + 1;
            promote_frame(slot, 32'hFFFF_FFFF);
         end else begin
            oldest = 0;
            for (int unsigned i = 1; i < n; i++) begin
               if (age_rank[i] > age_rank[oldest]) oldest = i;
            end
            slot = oldest;
            r.evicted_valid = 1'b1;
            r.evicted_page = resident_page[slot];
            resident_page[slot] = page;
            promote_frame(slot, 32'hFFFF_FFFF);
         end
      end
      r.frame_slot = SLOT_W'(slot);
      r.fault_total = fault_count;
      r.filled_frames = 4'(fill_count);
      return r;
   endfunction

   always @(negedge clock) begin
      if (reset || no_idle) begin
         rsp_chan.ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_chan.ready <= 1'b1;
         stall_left = idle_length();
      end
   end

   always @(posedge clock) begin
      lookup_result_type want;
      lookup_result_type got;
      string             bad;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.hit = rsp_chan.hit;
         got.frame_slot = rsp_chan.frame_slot;
         got.evicted_valid = rsp_chan.evicted_valid;
         got.evicted_page = rsp_chan.evicted_page;
         got.fault_total = rsp_chan.fault_total;
         got.filled_frames = rsp_chan.filled_frames;
         beats_checked++;
         if (got.hit === 1'b1) hits_seen++;
         if (got.evicted_valid === 1'b1) evictions_seen++;
         if (expected_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("[%0t] rsp beat with nothing expected: %p", $realtime, got);
         end else begin
            want = expected_q.pop_front();
            bad = "";
            if (got.hit !== want.hit) bad = {bad, " hit"};
            if (got.frame_slot !== want.frame_slot) bad = {bad, " frame_slot"};
            if (got.evicted_valid !== want.evicted_valid) bad = {bad, " evicted_valid"};
            if (got.evicted_page !== want.evicted_page) bad = {bad, " evicted_page"};
            if (got.fault_total !== want.fault_total) bad = {bad, " fault_total"};
            if (got.filled_frames !== want.filled_frames) bad = {bad, " filled_frames"};
            if (bad != "") begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("[%0t] mismatch in%s", $realtime, bad);
                  $display("   expected %p", want);
                  $display("   actual   %p", got);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding",
                  cycle_count, expected_q.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_page(input logic [15:0] page);
      int gap;
      gap = idle_length();
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.page_number <= page;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_q.insert(expected_q.size(), reference_page(page));
      beats_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      wait_idle();
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'({idx, 2'b00});
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == CSR_POLICY) policy_cfg = policy_type'(value[0]);
      else frames_cfg = value[3:0];
   endtask

   // capacity 0 acts as a single frame
   task automatic test_one_frame();
      csr_write(CSR_FRAMES, 32'd0);
      csr_write(CSR_POLICY, 32'(POLICY_LRU));
      send_page(16'h0000);
      send_page(16'h0000);
      send_page(16'hFFFF);
      send_page(16'hFFFF);
   endtask

   // capacity above the frame count clamps to eight
   task automatic test_lru_ranking();
      csr_write(CSR_FRAMES, 32'd15);
      send_page(16'hA5A5);
      send_page(16'h5A5A);
      for (int p = 3; p <= 7; p++) send_page(16'(p));
      send_page(16'h5A5A);
      send_page(16'hFFFF);
      send_page(16'h1234);
   endtask

   task automatic test_fifo_order();
      csr_write(CSR_POLICY, 32'hFFFF_FFFF);
      send_page(16'h0003);
      send_page(16'h8000);
      send_page(16'h0003);
   endtask

   // upper policy bits ignored
   task automatic test_policy_bit_only();
      csr_write(CSR_POLICY, 32'hFFFF_FFFE);
      send_page(16'h0005);
      send_page(16'h7FFF);
   endtask

   // all eight frames filled, capacity dropped to three
   task automatic test_capacity_lowered();
      csr_write(CSR_FRAMES, 32'hFFFF_FFF3);
      send_page(16'h0001);
      send_page(16'h0002);
      send_page(16'h0001);
   endtask

   task automatic run_random_phase(input policy_type pol, input logic [3:0] frames,
                                   input int count);
      logic [15:0] pool [12];
      int          pool_n;
      csr_write(CSR_POLICY, ($urandom() & 32'hFFFF_FFFE) | 32'(pol));
      csr_write(CSR_FRAMES, ($urandom() & 32'hFFFF_FFF0) | 32'(frames));
      pool_n = $urandom_range(2, 12);
      foreach (pool[k]) pool[k] = 16'($urandom());
      for (int k = 0; k < count; k++) begin
         if (k % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0) send_page(16'($urandom()));
         else send_page(pool[$urandom_range(0, pool_n - 1)]);
      end
      no_idle = 1'b0;
   endtask

   task automatic test_random_mix();
      logic [3:0] caps [RANDOM_PHASES] = '{4'd8, 4'd8, 4'd1, 4'd0, 4'd15, 4'd5, 4'd2, 4'd3};
      for (int k = 0; k < RANDOM_PHASES; k++)
         run_random_phase(policy_type'(k[0]), caps[k], PHASE_BEATS);
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_chan.valid = 1'b0;
      req_chan.page_number = '0;
      rsp_chan.ready = 1'b0;
      no_idle = 1'b0;
      stall_left = 0;
      policy_cfg = POLICY_LRU;
      frames_cfg = CFG_FRAMES_RESET;
      fill_count = 0;
      fault_count = '0;
      foreach (age_rank[i]) age_rank[i] = 0;
      foreach (resident_page[i]) resident_page[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_one_frame();
      test_lru_ranking();
      test_fifo_order();
      test_policy_bit_only();
      test_capacity_lowered();
      test_random_mix();

      wait_idle();
      repeat (8) @(posedge clock);
      $display("sent %0d page references, checked %0d rsp beats (%0d hits, %0d evictions)",
               beats_sent, beats_checked, hits_seen, evictions_seen);
      $display("both policies, capacities 0 through 15, %0d mismatches", mismatch_count);
      if (mismatch_count == 0 && expected_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/prf_pkg.sv
rtl/prf_if.sv
rtl/prf_frames.sv
rtl/page_frame_replacement_lru_fifo.sv
tb/sv/page_frame_replacement_lru_fifo_tb.sv
